[rtl/core/wtsp_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// wtsp_pkg
// shared types, constants and helpers of the world-to-screen projection core
// ----------------------------------------------------------------------------
package wtsp_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int QCAP_BITS     = 40;
    localparam int DIV_STEP_BITS = 2;
    localparam int SIZE_W        = 14;
    localparam int HALF_W        = SIZE_W - 1;
    localparam int THR_W         = 31;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 31;
    localparam int SUM_W         = QCAP_BITS + 3;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_HEIGHT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NEAR_THRESHOLD = 2'd2;

    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_PROJECT = 1'b1;

    localparam logic [SIZE_W-1:0] WIDTH_RST  = 14'd1920;
    localparam logic [SIZE_W-1:0] HEIGHT_RST = 14'd1080;
    localparam logic [THR_W-1:0]  NEAR_RST   = 31'd6554;

    typedef struct packed {
        logic               operation;
        logic [3:0]         coef_index;
        logic signed [31:0] coef_value;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
    } req_t;

    typedef struct packed {
        logic               on_screen;
        logic signed [31:0] screen_x;
        logic signed [31:0] screen_y;
    } resp_t;

    typedef struct packed {
        logic advance;
        logic accept;
    } pipe_ctrl_t;

    // clamp to signed 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] v);
        logic signed [31:0] r;
        if (v > $signed(SUM_W'(32'sh7fffffff)))
            r = 32'sh7fffffff;
        else if (v < -$signed(SUM_W'(64'h80000000)))
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage
`default_nettype wire

[rtl/core/wtsp_clip.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// wtsp_clip
// matrix store and two-stage clip transform (products, then row sums)
// ----------------------------------------------------------------------------
module wtsp_clip #(
    parameter int FRAC_BITS = wtsp_pkg::FRAC_BITS_DEF,
    parameter int CW        = 66 - FRAC_BITS
) (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wtsp_pkg::pipe_ctrl_t    ctrl,
    input  wtsp_pkg::req_t          req,
    output logic                    clip_valid,
    output logic signed [CW-1:0]    clip_x,
    output logic signed [CW-1:0]    clip_y,
    output logic signed [CW-1:0]    clip_w
);
    import wtsp_pkg::*;

    // rows 0, 1 and 3 of the matrix
    localparam int ROW_BASE [3] = '{0, 4, 12};

    logic signed [31:0] matrix_reg [16];
    logic signed [31:0] pos [3];
    logic signed [63:0] prod_reg [3][3];
    logic signed [63:0] prod_next [3][3];
    logic signed [31:0] bias_reg [3];
    logic signed [CW-1:0] clip_reg [3];
    logic signed [CW-1:0] clip_next [3];
    logic valid1_reg;
    logic valid2_reg;

    assign pos[0] = req.pos_x;
    assign pos[1] = req.pos_y;
    assign pos[2] = req.pos_z;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 16; i++)
                matrix_reg[i] <= '0;
        end
        else if (ctrl.accept && req.operation == OP_LOAD)
        begin
            matrix_reg[req.coef_index] <= req.coef_value;
        end
    end

    always_comb
    begin
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
                prod_next[r][c] = 64'(pos[c]) * 64'(matrix_reg[ROW_BASE[r] + c]);
    end

    // floor shift of each product, then exact row sum
    always_comb
    begin
        for (int r = 0; r < 3; r++)
            clip_next[r] = CW'(prod_reg[r][0] >>> FRAC_BITS)
                         + CW'(prod_reg[r][1] >>> FRAC_BITS)
                         + CW'(prod_reg[r][2] >>> FRAC_BITS)
                         + CW'(bias_reg[r]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid1_reg <= 1'b0;
            valid2_reg <= 1'b0;
        end
        else if (ctrl.advance)
        begin
            valid1_reg <= ctrl.accept && req.operation == OP_PROJECT;
            valid2_reg <= valid1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.advance)
        begin
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                    prod_reg[r][c] <= prod_next[r][c];
                bias_reg[r] <= matrix_reg[ROW_BASE[r] + 3];
                clip_reg[r] <= clip_next[r];
            end
        end
    end

    assign clip_valid = valid2_reg;
    assign clip_x     = clip_reg[0];
    assign clip_y     = clip_reg[1];
    assign clip_w     = clip_reg[2];

endmodule
`default_nettype wire

[rtl/core/wtsp_divider.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// wtsp_divider
// pipelined restoring divider, quotient capped at 2^QCAP_BITS
// ----------------------------------------------------------------------------
module wtsp_divider #(
    parameter int CW    = 50,
    parameter int NW    = 79,
    parameter int TAG_W = 1
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              advance,
    input  wire                              in_valid,
    input  wire [NW-1:0]                     num,
    input  wire [CW-1:0]                     den,
    input  wire [TAG_W-1:0]                  in_tag,
    output logic                             out_valid,
    output logic [wtsp_pkg::QCAP_BITS:0]     quot,
    output logic [TAG_W-1:0]                 out_tag
);
    import wtsp_pkg::*;

    localparam int NS   = QCAP_BITS / DIV_STEP_BITS;
    localparam int TW   = NW - QCAP_BITS;
    localparam int CMPW = (TW > CW) ? TW : CW;

    logic                 valid_reg [NS+1];
    logic [CW-1:0]        rem_reg   [NS+1];
    logic [QCAP_BITS-1:0] lo_reg    [NS+1];
    logic [QCAP_BITS-1:0] q_reg     [NS+1];
    logic [CW-1:0]        den_reg   [NS+1];
    logic                 big_reg   [NS+1];
    logic [TAG_W-1:0]     tag_reg   [NS+1];

    // first stage: upper part of the dividend, overflow check
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg[0] <= 1'b0;
        else if (advance)
            valid_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rem_reg[0] <= CW'(num[NW-1:QCAP_BITS]);
            lo_reg[0]  <= num[QCAP_BITS-1:0];
            q_reg[0]   <= '0;
            den_reg[0] <= den;
            big_reg[0] <= CMPW'(num[NW-1:QCAP_BITS]) >= CMPW'(den);
            tag_reg[0] <= in_tag;
        end
    end

    for (genvar k = 1; k <= NS; k++)
    begin : g_stage
        logic [CW-1:0]        rem_next;
        logic [QCAP_BITS-1:0] lo_next;
        logic [QCAP_BITS-1:0] q_next;

        always_comb
        begin
            logic [CW:0] t;
            rem_next = rem_reg[k-1];
            lo_next  = lo_reg[k-1];
            q_next   = q_reg[k-1];
            for (int j = 0; j < DIV_STEP_BITS; j++)
            begin
                t       = {rem_next, lo_next[QCAP_BITS-1]};
                lo_next = lo_next << 1;
                q_next  = q_next << 1;
                if (t >= {1'b0, den_reg[k-1]})
                begin
                    t         = t - {1'b0, den_reg[k-1]};
                    q_next[0] = 1'b1;
                end
                rem_next = t[CW-1:0];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[k] <= 1'b0;
            else if (advance)
                valid_reg[k] <= valid_reg[k-1];
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                rem_reg[k] <= rem_next;
                lo_reg[k]  <= lo_next;
                q_reg[k]   <= q_next;
                den_reg[k] <= den_reg[k-1];
                big_reg[k] <= big_reg[k-1];
                tag_reg[k] <= tag_reg[k-1];
            end
        end
    end

    assign out_valid = valid_reg[NS];
    assign out_tag   = tag_reg[NS];
    assign quot      = big_reg[NS] ? {1'b1, {QCAP_BITS{1'b0}}} : {1'b0, q_reg[NS]};

endmodule
`default_nettype wire

[rtl/core/world_to_screen_projection_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// world_to_screen_projection_core
// 4x4 perspective projection with viewport mapping, fully pipelined
// ----------------------------------------------------------------------------
// A load request (operation 0) writes one row-major coefficient of the 4x4
// matrix and gives no response; a project request (operation 1) gives one
// response with the screen position in signed Q16.16 pixels, saturated, or
// on_screen low and zero coordinates when clip w is below near_threshold or
// not positive. The core takes one request per cycle for as long as the
// response side keeps up; loads act on every project request taken after
// them. A project request passes through two stages of matrix products
// and row sums, two stages of sign handling and numerator scaling, then
// the two dividers of x/w and y/w, one overflow stage plus twenty stages
// of two quotient bits each, and the response register. req_stall rises
// only while a response is held by resp_stall. Configuration must be
// written while the core is idle.
// ----------------------------------------------------------------------------
module world_to_screen_projection_core #(
    parameter int FRAC_BITS = wtsp_pkg::FRAC_BITS_DEF
) (
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  wire                                   cfg_write,
    input  wire [wtsp_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  wire [wtsp_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  wire                                   req_valid,
    output logic                                  req_stall,
    input  wtsp_pkg::req_t                        req,
    output logic                                  resp_valid,
    input  wire                                   resp_stall,
    output wtsp_pkg::resp_t                       resp
);
    import wtsp_pkg::*;

    localparam int CW = 66 - FRAC_BITS;       // clip coordinate width
    localparam int PW = CW + HALF_W;          // magnitude times half size
    localparam int NW = PW + FRAC_BITS;       // dividend width
    localparam int SW = HALF_W + FRAC_BITS;   // screen offset width

    // configuration registers
    logic [SIZE_W-1:0] width_reg;
    logic [SIZE_W-1:0] height_reg;
    logic [THR_W-1:0]  near_reg;

    // handshake and pipeline control
    pipe_ctrl_t ctrl;
    logic       advance;

    // clip stage outputs
    logic                 clip_valid;
    logic signed [CW-1:0] clip_x;
    logic signed [CW-1:0] clip_y;
    logic signed [CW-1:0] clip_w;

    // sign and visibility stage
    logic          valid3_reg;
    logic          vis3_reg;
    logic          negx3_reg;
    logic          negy3_reg;
    logic [CW-1:0] magx3_reg;
    logic [CW-1:0] magy3_reg;
    logic [CW-1:0] w3_reg;
    logic signed [CW-1:0] thr_ext;

    // numerator stage
    logic          valid4_reg;
    logic          vis4_reg;
    logic          negx4_reg;
    logic          negy4_reg;
    logic [NW-1:0] numx4_reg;
    logic [NW-1:0] numy4_reg;
    logic [CW-1:0] w4_reg;
    logic [HALF_W-1:0] half_x;
    logic [HALF_W-1:0] half_y;

    // divider outputs
    logic                 divx_valid;
    logic                 divy_valid;
    logic [QCAP_BITS:0]   quot_x;
    logic [QCAP_BITS:0]   quot_y;
    logic [1:0]           tag_x;
    logic [0:0]           tag_y;

    // response stage
    logic                    resp_valid_reg;
    resp_t                   resp_reg;
    logic signed [SUM_W-1:0] sum_x;
    logic signed [SUM_W-1:0] sum_y;

    // the whole pipe moves unless a finished response is held
    assign advance      = !resp_valid_reg || !resp_stall;
    assign req_stall    = !advance;
    assign ctrl.advance = advance;
    assign ctrl.accept  = req_valid && advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RST;
            height_reg <= HEIGHT_RST;
            near_reg   <= NEAR_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_WINDOW_WIDTH:   width_reg  <= cfg_data[SIZE_W-1:0];
                CFG_WINDOW_HEIGHT:  height_reg <= cfg_data[SIZE_W-1:0];
                CFG_NEAR_THRESHOLD: near_reg   <= cfg_data[THR_W-1:0];
                default:            ;
            endcase
        end
    end

    assign half_x = width_reg[SIZE_W-1:1];
    assign half_y = height_reg[SIZE_W-1:1];

    wtsp_clip #(
        .FRAC_BITS (FRAC_BITS),
        .CW        (CW)
    ) u_clip (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .req        (req),
        .clip_valid (clip_valid),
        .clip_x     (clip_x),
        .clip_y     (clip_y),
        .clip_w     (clip_w)
    );

    // visibility test and magnitudes
    assign thr_ext = $signed({{(CW-THR_W){1'b0}}, near_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid3_reg <= 1'b0;
            valid4_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid3_reg <= clip_valid;
            valid4_reg <= valid3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            vis3_reg  <= (clip_w > $signed(CW'(0))) && (clip_w >= thr_ext);
            negx3_reg <= clip_x[CW-1];
            negy3_reg <= clip_y[CW-1];
            magx3_reg <= clip_x[CW-1] ? $unsigned(-clip_x) : $unsigned(clip_x);
            magy3_reg <= clip_y[CW-1] ? $unsigned(-clip_y) : $unsigned(clip_y);
            w3_reg    <= $unsigned(clip_w);

            // dividend is magnitude times half size, scaled to fixed point
            vis4_reg  <= vis3_reg;
            negx4_reg <= negx3_reg;
            negy4_reg <= negy3_reg;
            numx4_reg <= {PW'(magx3_reg) * PW'(half_x), {FRAC_BITS{1'b0}}};
            numy4_reg <= {PW'(magy3_reg) * PW'(half_y), {FRAC_BITS{1'b0}}};
            w4_reg    <= w3_reg;
        end
    end

    wtsp_divider #(
        .CW    (CW),
        .NW    (NW),
        .TAG_W (2)
    ) u_div_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (valid4_reg),
        .num       (numx4_reg),
        .den       (w4_reg),
        .in_tag    ({vis4_reg, negx4_reg}),
        .out_valid (divx_valid),
        .quot      (quot_x),
        .out_tag   (tag_x)
    );

    wtsp_divider #(
        .CW    (CW),
        .NW    (NW),
        .TAG_W (1)
    ) u_div_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (valid4_reg),
        .num       (numy4_reg),
        .den       (w4_reg),
        .in_tag    (negy4_reg),
        .out_valid (divy_valid),
        .quot      (quot_y),
        .out_tag   (tag_y)
    );

    // centre plus or minus offset; y is flipped
    always_comb
    begin
        if (tag_x[0])
            sum_x = $signed(SUM_W'({half_x, {FRAC_BITS{1'b0}}})) - $signed(SUM_W'(quot_x));
        else
            sum_x = $signed(SUM_W'({half_x, {FRAC_BITS{1'b0}}})) + $signed(SUM_W'(quot_x));
        if (!tag_y[0])
            sum_y = $signed(SUM_W'({half_y, {FRAC_BITS{1'b0}}})) - $signed(SUM_W'(quot_y));
        else
            sum_y = $signed(SUM_W'({half_y, {FRAC_BITS{1'b0}}})) + $signed(SUM_W'(quot_y));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            resp_valid_reg <= 1'b0;
        else if (advance)
            resp_valid_reg <= divx_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance && divx_valid)
        begin
            resp_reg.on_screen <= tag_x[1];
            resp_reg.screen_x  <= tag_x[1] ? sat32(sum_x) : 32'sd0;
            resp_reg.screen_y  <= tag_x[1] ? sat32(sum_y) : 32'sd0;
        end
    end

    assign resp_valid = resp_valid_reg;
    assign resp       = resp_reg;

    // both dividers carry the same requests
    a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        divx_valid == divy_valid)
        else $error("x and y dividers out of step");

    // back-pressure is the only reason to refuse a request
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> (resp_valid && resp_stall))
        else $error("request stalled without a held response");

    // hidden points carry zero coordinates
    a_hidden_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (resp_valid && !resp.on_screen) |-> (resp.screen_x == 32'sd0 && resp.screen_y == 32'sd0))
        else $error("hidden point with non-zero coordinates");

    // a project request leaves a valid bit in the first product stage
    a_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall && req.operation == OP_PROJECT) |=> u_clip.valid1_reg)
        else $error("project request lost at entry");

endmodule
`default_nettype wire
